/* sv/antialiased_line_stepper_unit_defines.svh */
// assertion macros for the antialiased line stepper
`ifndef ANTIALIASED_LINE_STEPPER_UNIT_DEFINES_SVH
`define ANTIALIASED_LINE_STEPPER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ALSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ALSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/alsu_pkg.sv */
// shared types and constants of the antialiased line stepper
package alsu_pkg;

    // default geometry
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // surface size registers
    localparam int REG_W = 11;
    localparam logic [REG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [REG_W-1:0] HEIGHT_RESET = 11'd480;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    // shade
    localparam int SHADE_W = 8;
    localparam logic [SHADE_W-1:0] SHADE_MAX = 8'd255;

    // item commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // line kinds
    typedef enum logic [1:0] {
        KIND_VERT = 2'd0,
        KIND_HORZ = 2'd1,
        KIND_XMAJ = 2'd2,
        KIND_YMAJ = 2'd3
    } t_kind;

    // controller to datapath commands
    typedef struct packed {
        logic load_start;
        logic emit_single;
        logic emit_neigh;
        logic emit_pair;
    } t_ctl;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
        logic active;
        logic diag;
        logic start_diag;
        logic div_busy;
    } t_stat;

endpackage

/* sv/alsu_div.sv */
// restoring divider for the slope, one quotient bit per cycle
module alsu_div #(
    parameter int COORD_BITS = alsu_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = alsu_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [COORD_BITS-1:0] i_num,
    input  logic [COORD_BITS-1:0] i_den,
    output logic [FRAC_BITS:0]    o_quot,
    output logic                  o_busy
);

    localparam int CW    = COORD_BITS;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [CW-1:0]    r_rem;
    logic [CW-1:0]    r_den;
    logic [FRAC_BITS:0] r_quot;
    logic [CNT_W-1:0] r_cnt;

    logic [CW:0]   rem_sh;
    logic          rem_ge;
    logic [CW:0]   rem_sub;
    logic          first_ge;
    logic [CW-1:0] first_rem;

    // numerator never exceeds denominator, so the integer part is one bit
    assign first_ge  = i_num >= i_den;
    assign first_rem = first_ge ? (i_num - i_den) : i_num;

    // one shift-and-subtract step
    assign rem_sh  = {r_rem, 1'b0};
    assign rem_ge  = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_rem  <= '0;
            r_den  <= '0;
            r_quot <= '0;
        end else if (i_load) begin
            r_cnt  <= CNT_W'(FRAC_BITS);
            r_rem  <= first_rem;
            r_den  <= i_den;
            r_quot <= {{FRAC_BITS{1'b0}}, first_ge};
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_rem  <= rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
            r_quot <= {r_quot[FRAC_BITS-1:0], rem_ge};
        end
    end

    assign o_quot = r_quot;
    assign o_busy = r_cnt != '0;

endmodule

/* sv/alsu_dp.sv */
// datapath: line state, error accumulator, pixel output register
module alsu_dp #(
    parameter int COORD_BITS = alsu_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = alsu_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [alsu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [alsu_pkg::REG_W-1:0]          i_cfg_data,
    input  logic signed [COORD_BITS-1:0]        i_x_start,
    input  logic signed [COORD_BITS-1:0]        i_y_start,
    input  logic signed [COORD_BITS-1:0]        i_x_end,
    input  logic signed [COORD_BITS-1:0]        i_y_end,
    input  alsu_pkg::t_ctl                      i_ctl,
    output alsu_pkg::t_stat                     o_stat,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [COORD_BITS-1:0]        o_pix_x,
    output logic signed [COORD_BITS-1:0]        o_pix_y,
    output logic [alsu_pkg::SHADE_W-1:0]        o_shade,
    output logic                                o_inside_res,
    output logic                                o_last_of_line
);

    localparam int CW     = COORD_BITS;
    localparam int SW     = COORD_BITS + 1;
    localparam int ACC_W  = FRAC_BITS + 8;
    localparam int DIFF_W = FRAC_BITS + 10;
    localparam int CMP_W  = (COORD_BITS > alsu_pkg::REG_W) ? COORD_BITS : alsu_pkg::REG_W;
    localparam int SH_W   = alsu_pkg::SHADE_W;

    // configuration registers
    logic [alsu_pkg::REG_W-1:0] r_width;
    logic [alsu_pkg::REG_W-1:0] r_height;

    // line state
    logic                 r_active, n_active;
    alsu_pkg::t_kind      r_kind, n_kind;
    logic [CW-1:0]        r_cur_x, n_cur_x;
    logic [CW-1:0]        r_cur_y, n_cur_y;
    logic [SW-1:0]        r_steps, n_steps;
    logic                 r_minor_sign, n_minor_sign;
    logic [ACC_W-1:0]     r_acc, n_acc;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic [CW-1:0]        r_pix_x;
    logic [CW-1:0]        r_pix_y;
    logic [SH_W-1:0]      r_shade;
    logic                 r_inside;
    logic                 r_last;

    // start decode
    logic          swap;
    logic [CW-1:0] sx1, sy1, sx2, sy2;
    logic [CW:0]   dx, dy, dy_neg;
    logic [CW-1:0] adx, ady;
    logic          x_eq, y_eq, x_major;
    logic [CW-1:0] y_min;
    logic          div_load;
    logic [CW-1:0] div_num, div_den;
    logic [FRAC_BITS:0] quot;
    logic          div_busy;

    // step arithmetic
    logic [CW:0]       dir_w;
    logic [CW:0]       cur_x_w, cur_y_w, nbr_x, nbr_y;
    logic [CW-1:0]     minor_step;
    logic [DIFF_W-1:0] acc_diff;
    logic              borrow;
    logic [SH_W-1:0]   shade_nb;
    logic              last_px;

    // emitted pixel
    logic [CW:0]     e_x, e_y;
    logic [SH_W-1:0] e_shade;
    logic            e_last;
    logic            e_inside;
    logic            emit;

    // order endpoints so that x grows
    assign swap = i_x_start > i_x_end;
    assign sx1  = swap ? i_x_end   : i_x_start;
    assign sy1  = swap ? i_y_end   : i_y_start;
    assign sx2  = swap ? i_x_start : i_x_end;
    assign sy2  = swap ? i_y_start : i_y_end;

    // deltas and magnitudes
    assign dx     = {sx2[CW-1], sx2} - {sx1[CW-1], sx1};
    assign dy     = {sy2[CW-1], sy2} - {sy1[CW-1], sy1};
    assign dy_neg = '0 - dy;
    assign adx    = dx[CW-1:0];
    assign ady    = dy[CW] ? dy_neg[CW-1:0] : dy[CW-1:0];
    assign x_eq   = i_x_start == i_x_end;
    assign y_eq   = i_y_start == i_y_end;
    assign x_major = adx > ady;
    assign y_min  = (i_y_start < i_y_end) ? i_y_start : i_y_end;

    // slope divider
    assign div_load = i_ctl.load_start && !x_eq && !y_eq;
    assign div_num  = x_major ? ady : adx;
    assign div_den  = x_major ? adx : ady;

    alsu_div #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (div_load),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_quot (quot),
        .o_busy (div_busy)
    );

    // neighbor offsets and error update
    assign dir_w      = r_minor_sign ? '1 : SW'(1);
    assign cur_x_w    = {r_cur_x[CW-1], r_cur_x};
    assign cur_y_w    = {r_cur_y[CW-1], r_cur_y};
    assign nbr_x      = cur_x_w + dir_w;
    assign nbr_y      = cur_y_w + dir_w;
    assign minor_step = r_minor_sign ? '1 : CW'(1);
    assign acc_diff   = {2'b00, r_acc} - {1'b0, quot, 8'h00};
    assign borrow     = acc_diff[DIFF_W-1];
    assign shade_nb   = r_acc[ACC_W-1 -: SH_W];
    assign last_px    = r_steps == SW'(1);

    // pixel selection
    always_comb begin
        e_x     = cur_x_w;
        e_y     = cur_y_w;
        e_shade = '0;
        e_last  = last_px;
        if (i_ctl.emit_neigh) begin
            if (r_kind == alsu_pkg::KIND_XMAJ) begin
                e_y = nbr_y;
            end else begin
                e_x = nbr_x;
            end
            e_shade = shade_nb;
            e_last  = 1'b0;
        end else if (i_ctl.emit_pair) begin
            e_shade = alsu_pkg::SHADE_MAX - shade_nb;
        end
    end

    assign e_inside = !e_x[CW] && !e_y[CW]
                   && (CMP_W'(e_x[CW-1:0]) < CMP_W'(r_width))
                   && (CMP_W'(e_y[CW-1:0]) < CMP_W'(r_height));
    assign emit = i_ctl.emit_single || i_ctl.emit_neigh || i_ctl.emit_pair;

    // next line state
    always_comb begin
        n_active     = r_active;
        n_kind       = r_kind;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_steps      = r_steps;
        n_minor_sign = r_minor_sign;
        n_acc        = r_acc;
        if (i_ctl.load_start) begin
            n_active     = 1'b1;
            n_acc        = {alsu_pkg::SHADE_MAX, {FRAC_BITS{1'b0}}};
            n_minor_sign = 1'b0;
            if (x_eq) begin
                n_kind  = alsu_pkg::KIND_VERT;
                n_cur_x = i_x_start;
                n_cur_y = y_min;
                n_steps = {1'b0, ady} + SW'(1);
            end else if (y_eq) begin
                n_kind  = alsu_pkg::KIND_HORZ;
                n_cur_x = sx1;
                n_cur_y = i_y_start;
                n_steps = {1'b0, adx} + SW'(1);
            end else if (x_major) begin
                n_kind       = alsu_pkg::KIND_XMAJ;
                n_cur_x      = sx1;
                n_cur_y      = sy1;
                n_minor_sign = dy[CW];
                n_steps      = {1'b0, adx} + SW'(1);
            end else begin
                n_kind       = alsu_pkg::KIND_YMAJ;
                n_cur_x      = dy[CW] ? sx2 : sx1;
                n_cur_y      = dy[CW] ? sy2 : sy1;
                n_minor_sign = dy[CW];
                n_steps      = {1'b0, ady} + SW'(1);
            end
        end else if (i_ctl.emit_single) begin
            n_steps  = r_steps - SW'(1);
            n_active = !last_px;
            if (r_kind == alsu_pkg::KIND_VERT) begin
                n_cur_y = r_cur_y + CW'(1);
            end else begin
                n_cur_x = r_cur_x + CW'(1);
            end
        end else if (i_ctl.emit_pair) begin
            n_steps  = r_steps - SW'(1);
            n_active = !last_px;
            n_acc    = acc_diff[ACC_W-1:0];
            if (r_kind == alsu_pkg::KIND_XMAJ) begin
                n_cur_x = r_cur_x + CW'(1);
                if (borrow) begin
                    n_cur_y = r_cur_y + minor_step;
                end
            end else begin
                n_cur_y = r_cur_y + CW'(1);
                if (borrow) begin
                    n_cur_x = r_cur_x + minor_step;
                end
            end
        end
    end

    // output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // surface size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= alsu_pkg::WIDTH_RESET;
            r_height <= alsu_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                alsu_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                alsu_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_kind       <= alsu_pkg::KIND_VERT;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_steps      <= '0;
            r_minor_sign <= 1'b0;
            r_acc        <= {alsu_pkg::SHADE_MAX, {FRAC_BITS{1'b0}}};
            r_out_valid  <= 1'b0;
        end else begin
            r_active     <= n_active;
            r_kind       <= n_kind;
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_steps      <= n_steps;
            r_minor_sign <= n_minor_sign;
            r_acc        <= n_acc;
            r_out_valid  <= n_out_valid;
        end
    end

    // pixel payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pix_x  <= e_x[CW-1:0];
            r_pix_y  <= e_y[CW-1:0];
            r_shade  <= e_shade;
            r_inside <= e_inside;
            r_last   <= e_last;
        end
    end

    // status back to the controller
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_stat.active     = r_active;
    assign o_stat.diag       = (r_kind == alsu_pkg::KIND_XMAJ) || (r_kind == alsu_pkg::KIND_YMAJ);
    assign o_stat.start_diag = !x_eq && !y_eq;
    assign o_stat.div_busy   = div_busy;

    assign o_out_valid    = r_out_valid;
    assign o_pix_x        = r_pix_x;
    assign o_pix_y        = r_pix_y;
    assign o_shade        = r_shade;
    assign o_inside_res   = r_inside;
    assign o_last_of_line = r_last;

endmodule

/* sv/alsu_ctrl.sv */
// controller: item intake, slope setup wait, second pixel of a pair
module alsu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_cmd,
    output logic            o_in_stall,
    input  alsu_pkg::t_stat i_stat,
    output alsu_pkg::t_ctl  o_ctl
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_PAIR = 3'b100
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    if (i_cmd == alsu_pkg::CMD_START) begin
                        o_ctl.load_start = 1'b1;
                        if (i_stat.start_diag) begin
                            n_state = ST_DIV;
                        end
                    end else if (i_stat.active) begin
                        if (i_stat.diag) begin
                            o_ctl.emit_neigh = 1'b1;
                            n_state          = ST_PAIR;
                        end else begin
                            o_ctl.emit_single = 1'b1;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAIR: begin
                if (i_stat.out_free) begin
                    o_ctl.emit_pair = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/antialiased_line_stepper_unit.sv */
// Antialiased line stepper: start items load a line, step items emit its pixels.
// Axis-aligned step: its one pixel is in the output register the cycle after the item is taken.
// Diagonal step: neighbor pixel, then the on-line pixel once the output register is free.
// Diagonal start: intake waits in ST_DIV for the one-bit-per-cycle slope divider.
// Synchronous active-low reset: no active line, surface 640 x 480, output empty.
`include "antialiased_line_stepper_unit_defines.svh"

module antialiased_line_stepper_unit #(
    parameter int COORD_BITS = alsu_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = alsu_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [alsu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [alsu_pkg::REG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_cmd,
    input  logic signed [COORD_BITS-1:0]    i_x_start,
    input  logic signed [COORD_BITS-1:0]    i_y_start,
    input  logic signed [COORD_BITS-1:0]    i_x_end,
    input  logic signed [COORD_BITS-1:0]    i_y_end,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [COORD_BITS-1:0]    o_pix_x,
    output logic signed [COORD_BITS-1:0]    o_pix_y,
    output logic [alsu_pkg::SHADE_W-1:0]    o_shade,
    output logic                            o_inside_res,
    output logic                            o_last_of_line
);

    alsu_pkg::t_ctl  s_ctl;
    alsu_pkg::t_stat s_stat;

    // sequencer
    alsu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_cmd     (i_cmd),
        .o_in_stall(o_in_stall),
        .i_stat    (s_stat),
        .o_ctl     (s_ctl)
    );

    // line datapath
    alsu_dp #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_ctl         (s_ctl),
        .o_stat        (s_stat),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_pix_x       (o_pix_x),
        .o_pix_y       (o_pix_y),
        .o_shade       (o_shade),
        .o_inside_res  (o_inside_res),
        .o_last_of_line(o_last_of_line)
    );

    // a full, stalled output register blocks intake
    `ALSU_ASSERT_NOW(a_full_blocks_in, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall, "item accepted while output blocked")

    // at most one datapath command per cycle
    `ALSU_ASSERT_NOW(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({s_ctl.load_start, s_ctl.emit_single, s_ctl.emit_neigh, s_ctl.emit_pair}), "conflicting datapath commands")

    // the neighbor pixel is always followed by its pair before new intake
    `ALSU_ASSERT_NEXT(a_pair_holds_in, i_clk, i_rst_n, s_ctl.emit_neigh, o_in_stall && !s_ctl.load_start, "intake between the two pixels of a step")

    // the line ends exactly with the pixel marked last
    `ALSU_ASSERT_NEXT(a_last_ends_line, i_clk, i_rst_n, s_ctl.emit_single || s_ctl.emit_pair, o_last_of_line == !s_stat.active, "last flag and line activity disagree")

endmodule
